// ===== hdl/plsag_pkg.sv =====
`default_nettype none

package plsag_pkg;

    localparam int SLICES_DEF       = 360;
    localparam int LEDS_PER_ARM_DEF = 20;

    localparam int SLICE_IW  = 9;
    localparam int LED_IW    = 6;
    localparam int COORD_W   = 12;
    localparam int OFF_W     = 26;
    localparam int SIDE_W    = 13;
    localparam int STRIDE_W  = 15;
    localparam int BPP_W     = 3;
    localparam int CFG_DW    = 15;
    localparam int CFG_IW    = 2;
    localparam int TRIG_W    = 17;
    localparam int FRAC_SH   = 23;
    localparam int CENTRE_W  = 12;
    localparam int STEP_N_W  = 20;

    localparam logic [CFG_IW-1:0] CFG_CANVAS_SIDE = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_ROW_STRIDE  = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_BPP         = 2'd2;

    localparam logic [SIDE_W-1:0]   CANVAS_SIDE_RST = 13'd1800;
    localparam logic [STRIDE_W-1:0] ROW_STRIDE_RST  = 15'd5400;
    localparam logic [BPP_W-1:0]    BPP_RST         = 3'd3;

    localparam longint Q30    = 64'sd1073741824;
    localparam longint PI_Q30 = 64'sd3373259426;

    function automatic longint qmul(input longint x, input longint y);
        return (x * y) / Q30;
    endfunction

    function automatic logic signed [TRIG_W-1:0] to_q15(input longint v);
        longint r;
        if (v >= 0)
        begin
            r = (v + 16384) / 32768;
        end
        else
        begin
            r = -((-v + 16384) / 32768);
        end
        return TRIG_W'(r);
    endfunction

    // sine in the upper half, cosine in the lower half
    function automatic logic [2*TRIG_W-1:0] trig_pair(input longint ang, input longint quad);
        longint a2;
        longint s;
        longint c;
        logic signed [TRIG_W-1:0] sv;
        logic signed [TRIG_W-1:0] cv;
        a2 = qmul(ang, ang);
        s = Q30 - a2 / 42;
        s = Q30 - qmul(a2 / 20, s);
        s = Q30 - qmul(a2 / 6, s);
        s = qmul(ang, s);
        c = Q30 - a2 / 56;
        c = Q30 - qmul(a2 / 30, c);
        c = Q30 - qmul(a2 / 12, c);
        c = Q30 - qmul(a2 / 2, c);
        case (quad & 3)
            0:
            begin
                sv = to_q15(s);
                cv = to_q15(c);
            end
            1:
            begin
                sv = to_q15(c);
                cv = to_q15(-s);
            end
            2:
            begin
                sv = to_q15(-s);
                cv = to_q15(-c);
            end
            default:
            begin
                sv = to_q15(-c);
                cv = to_q15(s);
            end
        endcase
        return {sv, cv};
    endfunction

endpackage

`default_nettype wire

// ===== hdl/plsag_if.sv =====
`default_nettype none

interface plsag_in_if import plsag_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SLICE_IW-1:0] slice_index;
    logic [LED_IW-1:0]   led_position;

    modport source (output valid, output slice_index, output led_position, input ready);
    modport sink   (input valid, input slice_index, input led_position, output ready);
endinterface

interface plsag_out_if import plsag_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_column;
    logic [COORD_W-1:0] pixel_row;
    logic [OFF_W-1:0]   byte_offset;

    modport source (output valid, output pixel_column, output pixel_row, output byte_offset,
                    input ready);
    modport sink   (input valid, input pixel_column, input pixel_row, input byte_offset,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/polar_led_sample_address_gen_top.sv =====
// Throughput: one item per cycle while the output is not stalled; seven register
// stages, the output register the last.
// Stages: slice and step reciprocals, remainder and distance, table read,
// trig products, centre offset and clamp, offset products, offset sum.
// Reset clears all stage valid bits and loads the default configuration.
`default_nettype none

module polar_led_sample_address_gen_top import plsag_pkg::*; #(
    parameter int SLICES       = SLICES_DEF,
    parameter int LEDS_PER_ARM = LEDS_PER_ARM_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [CFG_IW-1:0] cfg_index,
    input  wire logic [CFG_DW-1:0] cfg_wdata,
    plsag_in_if.sink               item,
    plsag_out_if.source            result
);

    localparam int NST         = 7;
    localparam int SLICE_W     = $clog2(SLICES);
    localparam int SLICE_SH    = SLICE_IW + $clog2(SLICES);
    localparam longint SLICE_RCP = ((64'sd1 <<< SLICE_SH) + SLICES - 1) / SLICES;
    localparam int SLICE_RCP_W = SLICE_SH + 1;
    localparam int SLICE_PW    = SLICE_IW + SLICE_RCP_W;
    localparam int SQ_W        = SLICE_PW - SLICE_SH;
    localparam int MOD_W       = SQ_W + 11;
    localparam int K_W         = (LEDS_PER_ARM > 1) ? $clog2(LEDS_PER_ARM) : 1;
    localparam int FACT_W      = K_W + 2;
    localparam int POS_W       = LED_IW + 2;
    localparam int STEP_SH     = STEP_N_W + $clog2(LEDS_PER_ARM);
    localparam longint STEP_RCP = ((64'sd1 <<< STEP_SH) + LEDS_PER_ARM - 1) / LEDS_PER_ARM;
    localparam int STEP_RCP_W  = STEP_SH + 1;
    localparam int STEP_PW     = STEP_N_W + STEP_RCP_W;
    localparam int DIST_W      = STEP_N_W + FACT_W - 2;
    localparam int PROD_W      = DIST_W + 1 + TRIG_W;
    localparam int ACC_W       = PROD_W + 1;
    localparam int QT_W        = ACC_W - FRAC_SH;
    localparam int YOFF_W      = COORD_W + STRIDE_W;
    localparam int XOFF_W      = COORD_W + BPP_W;

    localparam logic [SLICE_RCP_W-1:0] SLICE_RCP_C = SLICE_RCP_W'(SLICE_RCP);
    localparam logic [STEP_RCP_W-1:0]  STEP_RCP_C  = STEP_RCP_W'(STEP_RCP);
    localparam logic [MOD_W-1:0]       SLICES_C    = MOD_W'(SLICES);
    localparam logic [POS_W-1:0]       LEDS_C      = POS_W'(LEDS_PER_ARM);
    localparam logic [POS_W-1:0]       TWO_LEDS_C  = POS_W'(2 * LEDS_PER_ARM);
    localparam logic [ACC_W-1:0]       ROUND_C     = ACC_W'((64'sd1 <<< FRAC_SH) - 1);

    logic signed [TRIG_W-1:0] sin_rom [SLICES];
    logic signed [TRIG_W-1:0] cos_rom [SLICES];

    for (genvar gi = 0; gi < SLICES; gi++)
    begin : g_rom
        localparam longint QUAD = (8 * longint'(gi) + SLICES) / (2 * SLICES);
        localparam longint R4   = 4 * longint'(gi) - QUAD * SLICES;
        localparam longint ANG  = (R4 * PI_Q30) / (2 * SLICES);
        localparam logic [2*TRIG_W-1:0] PAIR = trig_pair(ANG, QUAD);
        assign sin_rom[gi] = PAIR[2*TRIG_W-1:TRIG_W];
        assign cos_rom[gi] = PAIR[TRIG_W-1:0];
    end

    // configuration
    logic [SIDE_W-1:0]   canvas_side_reg;
    logic [STRIDE_W-1:0] row_stride_reg;
    logic [BPP_W-1:0]    bpp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_side_reg <= CANVAS_SIDE_RST;
            row_stride_reg  <= ROW_STRIDE_RST;
            bpp_reg         <= BPP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CANVAS_SIDE: canvas_side_reg <= cfg_wdata[SIDE_W-1:0];
                CFG_ROW_STRIDE:  row_stride_reg  <= cfg_wdata[STRIDE_W-1:0];
                CFG_BPP:         bpp_reg         <= cfg_wdata[BPP_W-1:0];
                default:         ;
            endcase
        end
    end

    // stage valid bits and advance enables
    logic [NST:1] valid_reg;
    logic [NST:1] en;

    always_comb
    begin
        en[NST] = !valid_reg[NST] || result.ready;
        for (int i = NST - 1; i >= 1; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    assign item.ready   = en[1];
    assign result.valid = valid_reg[NST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                valid_reg[1] <= item.valid;
            end
            for (int i = 2; i <= NST; i++)
            begin
                if (en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    logic [CENTRE_W-1:0] centre;
    assign centre = canvas_side_reg[SIDE_W-1:1];

    // stage 1: slice quotient, arm factor, radial step
    logic [SLICE_IW-1:0] slice1_reg;
    logic [SQ_W-1:0]     sq1_reg,     sq1_next;
    logic                neg1_reg,    neg1_next;
    logic [FACT_W-1:0]   fact1_reg,   fact1_next;
    logic [STEP_N_W-1:0] step1_reg,   step1_next;
    logic [SLICE_PW-1:0] slice_prod;
    logic [STEP_PW-1:0]  step_prod;
    logic [POS_W-1:0]    pos_c;
    logic [POS_W-1:0]    k_full;

    always_comb
    begin
        slice_prod = SLICE_PW'(item.slice_index) * SLICE_PW'(SLICE_RCP_C);
        sq1_next   = slice_prod[SLICE_PW-1:SLICE_SH];
        step_prod  = STEP_PW'({centre, 8'd0}) * STEP_PW'(STEP_RCP_C);
        step1_next = step_prod[STEP_SH +: STEP_N_W];
        pos_c      = POS_W'(item.led_position);
        if (pos_c >= TWO_LEDS_C)
        begin
            pos_c = TWO_LEDS_C - POS_W'(1);
        end
        if (pos_c >= LEDS_C)
        begin
            k_full     = pos_c - LEDS_C;
            neg1_next  = 1'b0;
            fact1_next = {k_full[K_W-1:0], 2'b01};
        end
        else
        begin
            k_full     = LEDS_C - POS_W'(1) - pos_c;
            neg1_next  = 1'b1;
            fact1_next = {k_full[K_W-1:0], 2'b11};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            slice1_reg <= item.slice_index;
            sq1_reg    <= sq1_next;
            neg1_reg   <= neg1_next;
            fact1_reg  <= fact1_next;
            step1_reg  <= step1_next;
        end
    end

    // stage 2: slice remainder, distance
    logic [SLICE_W-1:0] idx2_reg,  idx2_next;
    logic [DIST_W-1:0]  dist2_reg, dist2_next;
    logic               neg2_reg;
    logic [MOD_W-1:0]   mod_full;
    logic [STEP_N_W+FACT_W-1:0] dist_prod;

    always_comb
    begin
        mod_full   = MOD_W'(slice1_reg) - MOD_W'(sq1_reg) * SLICES_C;
        idx2_next  = mod_full[SLICE_W-1:0];
        dist_prod  = (STEP_N_W+FACT_W)'(step1_reg) * (STEP_N_W+FACT_W)'(fact1_reg);
        dist2_next = dist_prod[STEP_N_W+FACT_W-1:2];
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            idx2_reg  <= idx2_next;
            dist2_reg <= dist2_next;
            neg2_reg  <= neg1_reg;
        end
    end

    // stage 3: table read, arm B turns half a revolution
    logic signed [TRIG_W-1:0] sin3_reg, sin3_next;
    logic signed [TRIG_W-1:0] cos3_reg, cos3_next;
    logic [DIST_W-1:0]        dist3_reg;

    always_comb
    begin
        sin3_next = neg2_reg ? -sin_rom[idx2_reg] : sin_rom[idx2_reg];
        cos3_next = neg2_reg ? -cos_rom[idx2_reg] : cos_rom[idx2_reg];
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            sin3_reg  <= sin3_next;
            cos3_reg  <= cos3_next;
            dist3_reg <= dist2_reg;
        end
    end

    // stage 4: distance times sine and cosine
    logic signed [PROD_W-1:0] xp4_reg, xp4_next;
    logic signed [PROD_W-1:0] yp4_reg, yp4_next;
    logic signed [DIST_W:0]   dist_s;

    always_comb
    begin
        dist_s   = $signed({1'b0, dist3_reg});
        xp4_next = PROD_W'(dist_s * sin3_reg);
        yp4_next = PROD_W'(dist_s * cos3_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            xp4_reg <= xp4_next;
            yp4_reg <= yp4_next;
        end
    end

    // stage 5: offset from centre, truncate toward zero, clamp
    logic [COORD_W-1:0]      col5_reg, col5_next;
    logic [COORD_W-1:0]      row5_reg, row5_next;
    logic signed [ACC_W-1:0] centre_acc;
    logic signed [ACC_W-1:0] xacc;
    logic signed [ACC_W-1:0] yacc;
    logic signed [ACC_W-1:0] xadj;
    logic signed [ACC_W-1:0] yadj;
    logic signed [QT_W-1:0]  xq;
    logic signed [QT_W-1:0]  yq;
    logic signed [QT_W-1:0]  hi;

    always_comb
    begin
        centre_acc = $signed(ACC_W'({centre, FRAC_SH'(0)}));
        xacc = centre_acc - ACC_W'(xp4_reg);
        yacc = centre_acc + ACC_W'(yp4_reg);
        xadj = xacc[ACC_W-1] ? xacc + $signed(ROUND_C) : xacc;
        yadj = yacc[ACC_W-1] ? yacc + $signed(ROUND_C) : yacc;
        xq   = xadj[ACC_W-1:FRAC_SH];
        yq   = yadj[ACC_W-1:FRAC_SH];
        hi   = (canvas_side_reg > SIDE_W'(4096)) ? QT_W'(4095)
             : $signed(QT_W'(canvas_side_reg)) - QT_W'(1);
        if (xq > hi)
        begin
            xq = hi;
        end
        if (xq < 0)
        begin
            xq = '0;
        end
        if (yq > hi)
        begin
            yq = hi;
        end
        if (yq < 0)
        begin
            yq = '0;
        end
        col5_next = xq[COORD_W-1:0];
        row5_next = yq[COORD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            col5_reg <= col5_next;
            row5_reg <= row5_next;
        end
    end

    // stage 6: offset products
    logic [COORD_W-1:0] col6_reg;
    logic [COORD_W-1:0] row6_reg;
    logic [YOFF_W-1:0]  yoff6_reg, yoff6_next;
    logic [XOFF_W-1:0]  xoff6_reg, xoff6_next;

    always_comb
    begin
        yoff6_next = YOFF_W'(row5_reg) * YOFF_W'(row_stride_reg);
        xoff6_next = XOFF_W'(col5_reg) * XOFF_W'(bpp_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            col6_reg  <= col5_reg;
            row6_reg  <= row5_reg;
            yoff6_reg <= yoff6_next;
            xoff6_reg <= xoff6_next;
        end
    end

    // stage 7: output register
    logic [COORD_W-1:0] col7_reg;
    logic [COORD_W-1:0] row7_reg;
    logic [OFF_W-1:0]   off7_reg, off7_next;
    logic [YOFF_W-1:0]  off_sum;

    always_comb
    begin
        off_sum   = yoff6_reg + YOFF_W'(xoff6_reg);
        off7_next = off_sum[OFF_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            col7_reg <= col6_reg;
            row7_reg <= row6_reg;
            off7_reg <= off7_next;
        end
    end

    assign result.pixel_column = col7_reg;
    assign result.pixel_row    = row7_reg;
    assign result.byte_offset  = off7_reg;

endmodule

`default_nettype wire

// ===== sim/polar_led_sample_address_gen_top_test.sv =====
module polar_led_sample_address_gen_top_test;
    import plsag_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     SLICES         = SLICES_DEF;
    localparam int     LEDS           = LEDS_PER_ARM_DEF;
    localparam longint ONE_Q30        = 64'sd1073741824;
    localparam longint PI_IN_Q30      = 64'sd3373259426;
    localparam longint FRAC_ONE       = 64'sd8388608;
    localparam int     PHASES         = 10;
    localparam int     ITEMS_PER_PHASE = 65;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     SLICE_MAX      = (1 << SLICE_IW) - 1;
    localparam int     LED_MAX        = (1 << LED_IW) - 1;

    typedef struct packed {
        logic [SLICE_IW-1:0] slice_index;
        logic [LED_IW-1:0]   led_position;
    } led_req_t;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_column;
        logic [COORD_W-1:0] pixel_row;
        logic [OFF_W-1:0]   byte_offset;
    } pixel_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [CFG_IW-1:0] cfg_index;
    logic [CFG_DW-1:0] cfg_wdata;

    plsag_in_if  item_ch ();
    plsag_out_if result_ch ();

    polar_led_sample_address_gen_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item      (item_ch),
        .result    (result_ch)
    );

    int sine_rom [SLICES];
    int cosine_rom [SLICES];

    logic [SIDE_W-1:0]   side_reg   = CANVAS_SIDE_RST;
    logic [STRIDE_W-1:0] stride_reg = ROW_STRIDE_RST;
    logic [BPP_W-1:0]    bpp_reg    = BPP_RST;

    led_req_t pending_leds [$];
    pixel_t   expected_pixels [$];
    int       queued_count   = 0;
    int       accepted_count = 0;
    int       failures       = 0;
    int       stalled_cycles = 0;
    int       send_gap       = 0;
    int       stall_left     = 0;
    bit       sender_idles   = 1'b1;
    bit       receiver_idles = 1'b1;

    always #10 clk = ~clk;

    function automatic longint q30_product(longint a, longint b);
        return (a * b) / ONE_Q30;
    endfunction

    function automatic int round_q15(longint v);
        if (v >= 0)
        begin
            return int'((v + 16384) / 32768);
        end
        return int'(-((-v + 16384) / 32768));
    endfunction

    function automatic void build_trig_rom();
        longint quad;
        longint rem4;
        longint ang;
        longint ang2;
        longint s;
        longint c;
        for (int i = 0; i < SLICES; i++)
        begin
            quad = (8 * i + SLICES) / (2 * SLICES);
            rem4 = 4 * i;
            rem4 = rem4 - quad * SLICES;
            ang  = (rem4 * PI_IN_Q30) / (2 * SLICES);
            ang2 = q30_product(ang, ang);
            s = ONE_Q30 - ang2 / 42;
            s = ONE_Q30 - q30_product(ang2 / 20, s);
            s = ONE_Q30 - q30_product(ang2 / 6, s);
            s = q30_product(ang, s);
            c = ONE_Q30 - ang2 / 56;
            c = ONE_Q30 - q30_product(ang2 / 30, c);
            c = ONE_Q30 - q30_product(ang2 / 12, c);
            c = ONE_Q30 - q30_product(ang2 / 2, c);
            case (quad % 4)
                0:
                begin
                    sine_rom[i]   = round_q15(s);
                    cosine_rom[i] = round_q15(c);
                end
                1:
                begin
                    sine_rom[i]   = round_q15(c);
                    cosine_rom[i] = round_q15(-s);
                end
                2:
                begin
                    sine_rom[i]   = round_q15(-s);
                    cosine_rom[i] = round_q15(-c);
                end
                default:
                begin
                    sine_rom[i]   = round_q15(-c);
                    cosine_rom[i] = round_q15(s);
                end
            endcase
        end
    endfunction

    function automatic pixel_t predict_pixel(logic [SLICE_IW-1:0] slice_raw,
                                             logic [LED_IW-1:0] led_raw);
        longint slc;
        longint led;
        longint factor;
        longint sn;
        longint cs;
        longint side;
        longint centre;
        longint stp;
        longint radius;
        longint hi;
        longint xv;
        longint yv;
        longint off;
        pixel_t px;
        slc = slice_raw;
        slc = slc % SLICES;
        led = led_raw;
        if (led >= 2 * LEDS)
        begin
            led = 2 * LEDS - 1;
        end
        sn = sine_rom[slc];
        cs = cosine_rom[slc];
        if (led >= LEDS)
        begin
            factor = 4 * (led - LEDS) + 1;
        end
        else
        begin
            factor = 4 * (LEDS - 1 - led) + 3;
            sn = -sn;
            cs = -cs;
        end
        side   = side_reg;
        centre = side / 2;
        stp    = (centre * 256) / LEDS;
        radius = (stp * factor) >>> 2;
        xv = (centre * FRAC_ONE - radius * sn) / FRAC_ONE;
        yv = (centre * FRAC_ONE + radius * cs) / FRAC_ONE;
        hi = ((side > 4096) ? 64'sd4096 : side) - 1;
        if (xv > hi)
        begin
            xv = hi;
        end
        if (xv < 0)
        begin
            xv = 0;
        end
        if (yv > hi)
        begin
            yv = hi;
        end
        if (yv < 0)
        begin
            yv = 0;
        end
        off = yv * longint'(stride_reg) + xv * longint'(bpp_reg);
        px.pixel_column = xv[COORD_W-1:0];
        px.pixel_row    = yv[COORD_W-1:0];
        px.byte_offset  = off[OFF_W-1:0];
        return px;
    endfunction

    function automatic led_req_t random_request();
        led_req_t r;
        if ($urandom_range(0, 9) == 0)
        begin
            r.slice_index = SLICE_IW'($urandom_range(SLICES, SLICE_MAX));
        end
        else
        begin
            r.slice_index = SLICE_IW'($urandom_range(0, SLICES - 1));
        end
        if ($urandom_range(0, 9) == 0)
        begin
            r.led_position = LED_IW'($urandom_range(2 * LEDS, LED_MAX));
        end
        else
        begin
            r.led_position = LED_IW'($urandom_range(0, 2 * LEDS - 1));
        end
        return r;
    endfunction

    task automatic queue_request(led_req_t r);
        pending_leds.push_back(r);
        queued_count++;
    endtask

    task automatic wait_drained();
        while (accepted_count != queued_count || expected_pixels.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_register(logic [CFG_IW-1:0] idx, int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DW'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic apply_settings(int side, int stride, int bpp);
        write_register(CFG_CANVAS_SIDE, side);
        write_register(CFG_ROW_STRIDE, stride);
        write_register(CFG_BPP, bpp);
        side_reg   = SIDE_W'(side);
        stride_reg = STRIDE_W'(stride);
        bpp_reg    = BPP_W'(bpp);
    endtask

    // hold the item until it is taken, then advance or leave a gap
    always @(posedge clk or negedge rst_n)
    begin
        led_req_t nxt;
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
        end
        else if (!item_ch.valid || item_ch.ready)
        begin
            if (send_gap > 0)
            begin
                item_ch.valid <= 1'b0;
                send_gap--;
            end
            else if (pending_leds.size() != 0)
            begin
                nxt = pending_leds.pop_front();
                item_ch.slice_index  <= nxt.slice_index;
                item_ch.led_position <= nxt.led_position;
                item_ch.valid        <= 1'b1;
                if (sender_idles && $urandom_range(0, 7) == 0)
                begin
                    send_gap = $urandom_range(1, 9);
                end
            end
            else
            begin
                item_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            result_ch.ready <= 1'b0;
            stall_left--;
        end
        else if (receiver_idles && $urandom_range(0, 7) == 0)
        begin
            result_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, 8);
        end
        else
        begin
            result_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        pixel_t want;
        bit     moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (item_ch.valid && item_ch.ready)
            begin
                expected_pixels.push_back(predict_pixel(item_ch.slice_index,
                                                        item_ch.led_position));
                accepted_count++;
                moved = 1'b1;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                moved = 1'b1;
                if (expected_pixels.size() == 0)
                begin
                    $error("unexpected transfer: pixel_column %0d, pixel_row %0d, byte_offset %0d",
                           result_ch.pixel_column, result_ch.pixel_row, result_ch.byte_offset);
                    failures++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (result_ch.pixel_column !== want.pixel_column)
                    begin
                        $error("pixel_column: expected %0d, actual %0d",
                               want.pixel_column, result_ch.pixel_column);
                        failures++;
                    end
                    if (result_ch.pixel_row !== want.pixel_row)
                    begin
                        $error("pixel_row: expected %0d, actual %0d",
                               want.pixel_row, result_ch.pixel_row);
                        failures++;
                    end
                    if (result_ch.byte_offset !== want.byte_offset)
                    begin
                        $error("byte_offset: expected %0d, actual %0d",
                               want.byte_offset, result_ch.byte_offset);
                        failures++;
                    end
                end
            end
            if (moved)
            begin
                stalled_cycles = 0;
            end
            else
            begin
                stalled_cycles++;
            end
            if (stalled_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        int       directed_slices [20] = '{0, 0, 90, 90, 180, 180, 270, 270, 359, 360,
                                           511, 45, 1, 256, 135, 225, 315, 170, 300, 128};
        int       directed_leds [20]   = '{20, 19, 39, 0, 20, 19, 39, 0, 63, 40,
                                           21, 10, 30, 5, 39, 0, 32, 42, 1, 18};
        int       side_list [PHASES]   = '{2, 0, 1, 4096, 8191, 4097, 0, 640, 0, 1800};
        int       stride_list [PHASES] = '{1, 0, 32767, 16384, 32767, 12288, 0, 1920, 0, 5400};
        int       bpp_list [PHASES]    = '{3, 0, 7, 4, 7, 5, 0, 3, 0, 3};
        led_req_t r;

        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = CFG_CANVAS_SIDE;
        cfg_wdata              = '0;
        item_ch.valid          = 1'b0;
        item_ch.slice_index    = '0;
        item_ch.led_position   = '0;
        result_ch.ready        = 1'b0;
        build_trig_rom();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 20; i++)
        begin
            r.slice_index  = SLICE_IW'(directed_slices[i]);
            r.led_position = LED_IW'(directed_leds[i]);
            queue_request(r);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            // let all traffic drain before touching the registers
            wait_drained();
            sender_idles   = (p != 4) && (p != PHASES - 1);
            receiver_idles = (p != 2) && (p != 4) && (p != PHASES - 1);
            if (p == 6 || p == 8)
            begin
                apply_settings($urandom_range(2, 4096), $urandom_range(1, 16384),
                               $urandom_range(3, 4));
            end
            else
            begin
                apply_settings(side_list[p], stride_list[p], bpp_list[p]);
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                queue_request(random_request());
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (failures == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
